// ===== sv/session_timeout_table_defines.svh =====
// Assertion macros shared by the session timeout table RTL.
`ifndef SESSION_TIMEOUT_TABLE_DEFINES_SVH
`define SESSION_TIMEOUT_TABLE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the same clock, masked while reset is asserted.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/stt_pkg.sv =====
// Types and constants for the session timeout table.
`default_nettype none
package stt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int FUNC_W      = 3;
  localparam int ID_W        = 16;
  localparam int AMT_W       = 24;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REFRESH = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_EXTEND  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_KEY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   key;
    logic [AMT_W-1:0]  base;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t data;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_INSERT,
    ST_ACK,
    ST_SCAN,
    ST_EXPIRE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/stt_cell.sv =====
// One table slot of the rotating ring: holds an entry, takes its neighbour's on shift.
`default_nettype none
module stt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stt_pkg::cell_ctl_t ctl,
  output stt_pkg::entry_t        q
);

  logic                       valid_r;
  logic [stt_pkg::ID_W-1:0]   key_r;
  logic [stt_pkg::AMT_W-1:0]  base_r;
  logic [stt_pkg::TIME_W-1:0] deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= ctl.data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r      <= ctl.data.key;
      base_r     <= ctl.data.base;
      deadline_r <= ctl.data.deadline;
    end
  end

  assign q = '{valid: valid_r, key: key_r, base: base_r, deadline: deadline_r};

endmodule
`default_nettype wire

// ===== sv/session_timeout_table.sv =====
// Session timeout table: ring of entry cells with one update head and a control sequencer.
//
//   channel | ports                                        | direction
//   in      | in_valid in_stall in_func in_session_id      | operation in
//           | in_amount_ms                                 |
//   out     | out_valid out_stall out_kind out_result_id   | ack / expiry out
//           | out_status out_last                          |
//
// Add, remove, refresh and extend make one ring rotation (an add that inserts makes two),
// then place the acknowledgement.
// A tick makes k+1 rotations, each followed by an expire step, when k sessions expire (k at most 16).
// The ring rotates one slot per cycle past the single head; only the find, insert and scan states shift it.
// Reset empties the table and zeroes the clock; no clearing pass is needed.
// A stalled result holds the sequencer only when it needs the output register again.
`default_nettype none
`include "session_timeout_table_defines.svh"
module session_timeout_table #(
  parameter int ENTRIES = stt_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [stt_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [stt_pkg::ID_W-1:0]     in_session_id,
  input  wire logic [stt_pkg::AMT_W-1:0]    in_amount_ms,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_kind,
  output logic [stt_pkg::ID_W-1:0]          out_result_id,
  output logic [stt_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_last
);

  localparam int CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int N_W   = $clog2(stt_pkg::MAX_RESULTS + 1);
  localparam int ID_W  = stt_pkg::ID_W;
  localparam int AMT_W = stt_pkg::AMT_W;
  localparam int T_W   = stt_pkg::TIME_W;

  stt_pkg::state_t state_r, state_nxt;

  stt_pkg::entry_t    ring [ENTRIES];
  stt_pkg::entry_t    e;
  stt_pkg::entry_t    head_out;
  logic               shift;

  logic [stt_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [AMT_W-1:0]   amt_r, amt_nxt;
  logic [T_W-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic               free_r, free_nxt;
  logic               ins_r, ins_nxt;
  logic               best_found_r, best_found_nxt;
  logic [T_W-1:0]     best_age_r, best_age_nxt;
  logic [ID_W-1:0]    best_key_r, best_key_nxt;
  logic               rm_pending_r, rm_pending_nxt;
  logic [ID_W-1:0]    rm_key_r, rm_key_nxt;
  logic [N_W-1:0]     n_r, n_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]            out_id_r, out_id_nxt;
  logic [stt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;

  logic               accept;
  logic               pass_end;
  logic               out_free;
  logic               hit;
  logic               removing;
  logic [T_W-1:0]     age;
  logic               better;
  logic               exp_last;
  logic [AMT_W:0]     base_sum;
  logic [stt_pkg::STATUS_W-1:0] ack_status;

  // Ring of cells; the last one takes the head's write-back.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    stt_pkg::cell_ctl_t ctl;
    if (g == ENTRIES - 1) begin : g_tail
      assign ctl = '{shift: shift, data: head_out};
    end else begin : g_mid
      assign ctl = '{shift: shift, data: ring[g+1]};
    end
    stt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .q     (ring[g])
    );
  end

  assign e        = ring[0];
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != stt_pkg::ST_IDLE);
  assign shift    = (state_r == stt_pkg::ST_FIND) || (state_r == stt_pkg::ST_INSERT) ||
                    (state_r == stt_pkg::ST_SCAN);
  assign pass_end = (cnt_r == CNT_W'(ENTRIES - 1));
  assign out_free = !out_valid_r || !out_stall;
  assign hit      = e.valid && (e.key == id_r);
  assign removing = e.valid && rm_pending_r && (e.key == rm_key_r);
  assign age      = now_r - e.deadline;
  assign better   = !best_found_r || (age > best_age_r) ||
                    ((age == best_age_r) && (e.key < best_key_r));
  assign exp_last = !best_found_r || (n_r == N_W'(stt_pkg::MAX_RESULTS - 1));
  assign base_sum = {1'b0, e.base} + {1'b0, amt_r};

  always_comb begin
    if (func_r == stt_pkg::FUNC_ADD) begin
      if (found_r) begin
        ack_status = stt_pkg::STATUS_KEY;
      end else if (!free_r) begin
        ack_status = stt_pkg::STATUS_FULL;
      end else begin
        ack_status = stt_pkg::STATUS_DONE;
      end
    end else begin
      ack_status = found_r ? stt_pkg::STATUS_DONE : stt_pkg::STATUS_KEY;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == stt_pkg::FUNC_TICK) begin
            state_nxt = stt_pkg::ST_SCAN;
          end else if (in_func < stt_pkg::FUNC_TICK) begin
            state_nxt = stt_pkg::ST_FIND;
          end
        end
      end
      stt_pkg::ST_FIND: begin
        if (pass_end) begin
          if ((func_r == stt_pkg::FUNC_ADD) && !(found_r || hit) && (free_r || !e.valid)) begin
            state_nxt = stt_pkg::ST_INSERT;
          end else begin
            state_nxt = stt_pkg::ST_ACK;
          end
        end
      end
      stt_pkg::ST_INSERT: begin
        if (pass_end) begin
          state_nxt = stt_pkg::ST_ACK;
        end
      end
      stt_pkg::ST_ACK: begin
        if (out_free) begin
          state_nxt = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_SCAN: begin
        if (pass_end) begin
          state_nxt = stt_pkg::ST_EXPIRE;
        end
      end
      stt_pkg::ST_EXPIRE: begin
        if (rm_pending_r) begin
          if (out_free) begin
            state_nxt = exp_last ? stt_pkg::ST_IDLE : stt_pkg::ST_SCAN;
          end
        end else begin
          state_nxt = best_found_r ? stt_pkg::ST_SCAN : stt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    func_nxt       = func_r;
    id_nxt         = id_r;
    amt_nxt        = amt_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    ins_nxt        = ins_r;
    best_found_nxt = best_found_r;
    best_age_nxt   = best_age_r;
    best_key_nxt   = best_key_r;
    rm_pending_nxt = rm_pending_r;
    rm_key_nxt     = rm_key_r;
    n_nxt          = n_r;
    head_out       = e;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    if (shift) begin
      cnt_nxt = pass_end ? '0 : cnt_r + 1'b1;
    end

    case (state_r)
      stt_pkg::ST_IDLE: begin
        if (accept) begin
          func_nxt       = in_func;
          id_nxt         = in_session_id;
          amt_nxt        = in_amount_ms;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          free_nxt       = 1'b0;
          ins_nxt        = 1'b0;
          best_found_nxt = 1'b0;
          rm_pending_nxt = 1'b0;
          n_nxt          = '0;
          if (in_func == stt_pkg::FUNC_TICK) begin
            now_nxt = now_r + 1'b1;
          end
        end
      end
      stt_pkg::ST_FIND: begin
        if (!e.valid) begin
          free_nxt = 1'b1;
        end
        if (hit) begin
          found_nxt = 1'b1;
          case (func_r)
            stt_pkg::FUNC_REMOVE: head_out.valid = 1'b0;
            stt_pkg::FUNC_REFRESH: head_out.deadline = now_r + T_W'(e.base);
            stt_pkg::FUNC_EXTEND: begin
              head_out.base     = base_sum[AMT_W] ? {AMT_W{1'b1}} : base_sum[AMT_W-1:0];
              head_out.deadline = e.deadline + T_W'(amt_r);
            end
            default: head_out = e;
          endcase
        end
      end
      stt_pkg::ST_INSERT: begin
        // take the first free slot that comes round
        if (!e.valid && !ins_r) begin
          ins_nxt  = 1'b1;
          head_out = '{valid: 1'b1, key: id_r, base: amt_r,
                       deadline: now_r + T_W'(amt_r)};
        end
      end
      stt_pkg::ST_ACK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = stt_pkg::KIND_ACK;
          out_id_nxt     = id_r;
          out_status_nxt = ack_status;
          out_last_nxt   = 1'b1;
        end
      end
      stt_pkg::ST_SCAN: begin
        if (removing) begin
          head_out.valid = 1'b0;
        end else if (e.valid && !age[T_W-1] && better) begin
          best_found_nxt = 1'b1;
          best_age_nxt   = age;
          best_key_nxt   = e.key;
        end
      end
      stt_pkg::ST_EXPIRE: begin
        if (rm_pending_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = stt_pkg::KIND_EXPIRY;
            out_id_nxt     = rm_key_r;
            out_status_nxt = stt_pkg::STATUS_DONE;
            out_last_nxt   = exp_last;
            n_nxt          = n_r + 1'b1;
            rm_pending_nxt = 1'b0;
            if (!exp_last) begin
              rm_pending_nxt = 1'b1;
              rm_key_nxt     = best_key_r;
              best_found_nxt = 1'b0;
              cnt_nxt        = '0;
            end
          end
        end else if (best_found_r) begin
          rm_pending_nxt = 1'b1;
          rm_key_nxt     = best_key_r;
          best_found_nxt = 1'b0;
          cnt_nxt        = '0;
        end
      end
      default: head_out = e;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= stt_pkg::ST_IDLE;
      now_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      rm_pending_r <= 1'b0;
      best_found_r <= 1'b0;
      n_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      rm_pending_r <= rm_pending_nxt;
      best_found_r <= best_found_nxt;
      n_r          <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    amt_r        <= amt_nxt;
    found_r      <= found_nxt;
    free_r       <= free_nxt;
    ins_r        <= ins_nxt;
    best_age_r   <= best_age_nxt;
    best_key_r   <= best_key_nxt;
    rm_key_r     <= rm_key_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  `STT_ASSERT_IMP(a_expiry_done, out_valid && out_kind, out_status == stt_pkg::STATUS_DONE, "expiry with nonzero status")
  `STT_ASSERT_IMP(a_ack_last, out_valid && !out_kind, out_last, "acknowledgement not flagged last")
  `STT_ASSERT(a_expiry_cap, n_r <= N_W'(stt_pkg::MAX_RESULTS), "too many expiries in one tick")
  `STT_ASSERT_IMP(a_idle_ring_home, state_r == stt_pkg::ST_IDLE, cnt_r == '0, "ring left mid-rotation")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the session timeout table.
`default_nettype none
module testbench;
  import stt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ID_W-1:0] in_session_id = '0;
  logic [AMT_W-1:0] in_amount_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic [ID_W-1:0] out_result_id;
  logic [STATUS_W-1:0] out_status;
  logic out_last;

  session_timeout_table i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0] id;
    logic [AMT_W-1:0] amount;
  } op_t;

  typedef struct packed {
    logic kind;
    logic [ID_W-1:0] id;
    logic [STATUS_W-1:0] status;
    logic last;
  } reply_t;

  op_t pending_ops[$];
  reply_t expected_replies[$];
  int failures = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;

  // Own copy of the timer table.
  bit t_valid[SLOTS];
  logic [ID_W-1:0] t_key[SLOTS];
  logic [AMT_W-1:0] t_base[SLOTS];
  logic [TIME_W-1:0] t_deadline[SLOTS];
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic int find_session(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (t_valid[i] && t_key[i] == id) return i;
    return -1;
  endfunction

  function automatic int oldest_overdue();
    int best;
    logic [TIME_W-1:0] age, best_age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!t_valid[i]) continue;
      age = clock_ms - t_deadline[i];
      if (age[TIME_W-1]) continue;
      if (best < 0 || age > best_age || (age == best_age && t_key[i] < t_key[best])) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  task automatic predict_replies(op_t op);
    int s, n;
    logic [STATUS_W-1:0] st;
    logic [AMT_W:0] sum;
    reply_t r;
    st = STATUS_DONE;
    if (op.func == FUNC_TICK) begin
      clock_ms++;
      n = 0;
      while (n < MAX_RESULTS) begin
        s = oldest_overdue();
        if (s < 0) break;
        t_valid[s] = 1'b0;
        expected_replies.push_back('{KIND_EXPIRY, t_key[s], STATUS_DONE, 1'b0});
        n++;
      end
      if (n > 0) begin
        r = expected_replies.pop_back();
        r.last = 1'b1;
        expected_replies.push_back(r);
      end
      return;
    end
    if (op.func > FUNC_TICK) return;
    s = find_session(op.id);
    if (op.func == FUNC_ADD) begin
      if (s >= 0) st = STATUS_KEY;
      else begin
        s = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!t_valid[i]) s = i;
        if (s < 0) st = STATUS_FULL;
        else begin
          t_valid[s] = 1'b1;
          t_key[s] = op.id;
          t_base[s] = op.amount;
          t_deadline[s] = clock_ms + TIME_W'(op.amount);
        end
      end
    end else if (s < 0) st = STATUS_KEY;
    else if (op.func == FUNC_REMOVE) t_valid[s] = 1'b0;
    else if (op.func == FUNC_REFRESH) t_deadline[s] = clock_ms + TIME_W'(t_base[s]);
    else begin
      sum = {1'b0, t_base[s]} + {1'b0, op.amount};
      t_base[s] = sum[AMT_W] ? '1 : sum[AMT_W-1:0];
      t_deadline[s] = t_deadline[s] + TIME_W'(op.amount);
    end
    expected_replies.push_back('{KIND_ACK, op.id, st, 1'b1});
  endtask

  // Record each input transfer at the edge that takes it.
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_replies('{in_func, in_session_id, in_amount_ms});
      void'(pending_ops.pop_front());
      in_taken = 1'b1;
    end
  end

  // Driver: present items at the falling edge, advance on an accepted transfer.
  int send_gap = 0;
  always @(negedge clk) begin
    bit waiting;
    waiting = in_valid && !in_taken;
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (waiting) begin
        // hold the stalled item
      end else if (pending_ops.size() == 0 || hold_sender) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_func <= pending_ops[0].func;
        in_session_id <= pending_ops[0].id;
        in_amount_ms <= pending_ops[0].amount;
      end
    end
  end

  // Result stall in bursts.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    reply_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result id %0h", out_result_id);
        failures++;
      end else begin
        e = expected_replies.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind); failures++;
        end
        if (out_result_id !== e.id) begin
          $error("result_id: expected %0h, got %0h", e.id, out_result_id); failures++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status); failures++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); failures++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, logic [AMT_W-1:0] a);
    pending_ops.push_back('{f, id, a});
  endtask

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return AMT_W'($urandom);
      default: return AMT_W'($urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    logic [FUNC_W-1:0] f;
    logic [ID_W-1:0] id;
    int r;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: extremes, duplicates, full table, saturation, far deadline.
    queue_op(FUNC_ADD, 16'h0000, 24'd0);
    queue_op(FUNC_ADD, 16'hFFFF, 24'hFFFFFF);
    queue_op(FUNC_ADD, 16'h0000, 24'd3);
    queue_op(FUNC_REMOVE, 16'h1234, 24'd0);
    queue_op(FUNC_REFRESH, 16'h5555, 24'd0);
    queue_op(FUNC_EXTEND, 16'hAAAA, 24'd1);
    queue_op(FUNC_EXTEND, 16'hFFFF, 24'hFFFFFF);
    queue_op(FUNC_REFRESH, 16'hFFFF, 24'hFFFFFF);
    queue_op(FUNC_TICK, 16'hFFFF, 24'hFFFFFF);
    queue_op(3'd5, 16'h0001, 24'd1);
    queue_op(3'd7, 16'hFFFF, 24'hFFFFFF);
    queue_op(FUNC_REMOVE, 16'hFFFF, 24'd0);
    for (int i = 0; i < 17; i++) queue_op(FUNC_ADD, 16'(i + 100), 24'd2);
    queue_op(FUNC_TICK, 16'd0, 24'd0);
    queue_op(FUNC_TICK, 16'd0, 24'd0);
    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    // Pause the sender once every expiry has drained.
    hold_sender = 1'b1;
    repeat (40) @(posedge clk);
    hold_sender = 1'b0;

    // Random: mostly live sessions from a small id pool, ticks often.
    for (int i = 0; i < 160; i++) begin
      r = $urandom_range(0, 99);
      f = r < 30 ? FUNC_ADD : r < 40 ? FUNC_REMOVE : r < 50 ? FUNC_REFRESH :
          r < 60 ? FUNC_EXTEND : r < 97 ? FUNC_TICK : FUNC_W'($urandom_range(5, 7));
      id = $urandom_range(0, 3) == 0 ? ID_W'($urandom) : ID_W'($urandom_range(0, 23));
      if (i == 100) calm = 1'b1;
      queue_op(f, id, pick_amount());
      if (i % 50 == 0) wait (pending_ops.size() < 4);
    end
    // Flush remaining sessions with a final burst of ticks.
    for (int i = 0; i < 20; i++) queue_op(FUNC_TICK, 16'd0, 24'd0);
    wait (pending_ops.size() == 0 && expected_replies.size() == 0);
    repeat (600) @(posedge clk);
    if (failures == 0 && expected_replies.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
